@@ sv/cmap_pkg.sv @@
// Package for the scalar-to-RGB colormap: widths, register and map codes,
// shared types and the colormap segment tables.
// No dependencies; every other file imports it.
`default_nettype none

package cmap_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int CHANNEL_BITS = 8;
   localparam int CMAX         = (1 << CHANNEL_BITS) - 1;

   localparam int MAP_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_MAPS  = 18;
   localparam int MAX_SEGS  = 6;
   localparam int SEG_W     = 3;
   localparam int MUL_W     = 3;
   localparam int KW        = 5;

   // Arithmetic widths: n = v - min and d = max - min need one bit more than a sample.
   localparam int ND_W   = SAMPLE_BITS + 1;
   localparam int P_W    = 11;
   localparam int Q_W    = 10;
   localparam int R_W    = 10;
   localparam int CMP_W  = ND_W + KW + 1;
   localparam int PN_W   = P_W + ND_W;
   localparam int QD_W   = Q_W + ND_W;
   localparam int RD_W   = R_W + ND_W + 1;
   localparam int N_W    = PN_W + 1;
   localparam int NUM_W  = N_W + CHANNEL_BITS + 2;
   localparam int D_W    = RD_W + 1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;
   localparam int ODEPTH = 2;
   localparam int OPTR_W = 1;
   localparam int OCNT_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_SELECT = 2'd2;

   localparam logic signed [SAMPLE_BITS-1:0] RANGE_MIN_RESET  = SAMPLE_BITS'(82);
   localparam logic signed [SAMPLE_BITS-1:0] RANGE_MAX_RESET  = SAMPLE_BITS'(486);
   localparam logic [MAP_W-1:0]              MAP_SELECT_RESET = '0;

   localparam logic [MAP_W-1:0] MAP_RAINBOW1     = 5'd0;
   localparam logic [MAP_W-1:0] MAP_RAINBOW2     = 5'd1;
   localparam logic [MAP_W-1:0] MAP_RAINBOW3     = 5'd2;
   localparam logic [MAP_W-1:0] MAP_RAINBOW4     = 5'd3;
   localparam logic [MAP_W-1:0] MAP_RAINBOW5     = 5'd4;
   localparam logic [MAP_W-1:0] MAP_RAINBOW6     = 5'd5;
   localparam logic [MAP_W-1:0] MAP_RAINBOW7     = 5'd6;
   localparam logic [MAP_W-1:0] MAP_RAINBOW8     = 5'd7;
   localparam logic [MAP_W-1:0] MAP_BLUE_RED     = 5'd8;
   localparam logic [MAP_W-1:0] MAP_TANGERINE    = 5'd9;
   localparam logic [MAP_W-1:0] MAP_ORANGE       = 5'd10;
   localparam logic [MAP_W-1:0] MAP_YELLOW_RED   = 5'd11;
   localparam logic [MAP_W-1:0] MAP_GRAYSCALE    = 5'd12;
   localparam logic [MAP_W-1:0] MAP_FLAT_GRAY    = 5'd13;
   localparam logic [MAP_W-1:0] MAP_FLAT_BLUE    = 5'd14;
   localparam logic [MAP_W-1:0] MAP_BLUES        = 5'd15;
   localparam logic [MAP_W-1:0] MAP_YELLOW_GREEN = 5'd16;
   localparam logic [MAP_W-1:0] MAP_GREEN_PINK   = 5'd17;

   // One channel on one segment: f = (p*n + q*d) / (r*d).
   typedef struct packed {
      logic signed [P_W-1:0] p;
      logic signed [Q_W-1:0] q;
      logic [R_W-1:0]        r;
   } lin_type;

   // Index 0 is red, 1 green, 2 blue.
   typedef lin_type [2:0] coef_type;

   typedef struct packed {
      logic [MUL_W-1:0] m;
      logic [SEG_W-1:0] nseg;
      logic [MUL_W-1:0] kstep;
   } geom_type;

   typedef struct packed {
      logic signed [ND_W-1:0] n;
      logic signed [ND_W-1:0] d;
      coef_type               coef;
      logic                   blank;
      logic                   force_clip;
   } item_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic                    clipped;
   } rsp_type;

   function automatic lin_type mk_lin(input int p, input int q, input int r);
      lin_type l;
      l.p = P_W'(p);
      l.q = Q_W'(q);
      l.r = R_W'(r);
      return l;
   endfunction

   function automatic coef_type mk_coef(input lin_type red, input lin_type green,
                                        input lin_type blue);
      coef_type c;
      c[0] = red;
      c[1] = green;
      c[2] = blue;
      return c;
   endfunction

   function automatic geom_type mk_geom(input int m, input int nseg, input int kstep);
      geom_type g;
      g.m     = MUL_W'(m);
      g.nseg  = SEG_W'(nseg);
      g.kstep = MUL_W'(kstep);
      return g;
   endfunction

   localparam lin_type Z0  = mk_lin(0, 0, 1);
   localparam lin_type ONE = mk_lin(0, 1, 1);
   localparam lin_type TUP = mk_lin(1, 0, 1);
   localparam lin_type TDN = mk_lin(-1, 1, 1);

   // Segment boundaries sit at t = i*kstep/m for i = 1 .. nseg-1.
   function automatic geom_type cmap_geom(input logic [MAP_W-1:0] code);
      geom_type g;
      case (code)
         MAP_RAINBOW1: g = mk_geom(4, 4, 1);
         MAP_RAINBOW2: g = mk_geom(6, 6, 1);
         MAP_RAINBOW3: g = mk_geom(4, 4, 1);
         MAP_RAINBOW4: g = mk_geom(3, 3, 1);
         MAP_RAINBOW5: g = mk_geom(5, 5, 1);
         MAP_RAINBOW6: g = mk_geom(4, 4, 1);
         MAP_RAINBOW7: g = mk_geom(2, 2, 1);
         MAP_RAINBOW8: g = mk_geom(2, 2, 1);
         MAP_ORANGE:   g = mk_geom(5, 2, 2);
         default:      g = mk_geom(1, 1, 1);
      endcase
      return g;
   endfunction

   function automatic coef_type cmap_coef(input logic [MAP_W-1:0] code,
                                          input logic [SEG_W-1:0] seg);
      coef_type c;
      c = mk_coef(Z0, Z0, Z0);
      case (code)
         MAP_RAINBOW1: begin
            case (seg)
               SEG_W'(0): c = mk_coef(Z0, mk_lin(4, 0, 1), ONE);
               SEG_W'(1): c = mk_coef(Z0, ONE, mk_lin(-4, 2, 1));
               SEG_W'(2): c = mk_coef(mk_lin(4, -2, 1), ONE, Z0);
               default:   c = mk_coef(ONE, mk_lin(-4, 4, 1), Z0);
            endcase
         end
         MAP_RAINBOW2: begin
            case (seg)
               SEG_W'(0): c = mk_coef(ONE, mk_lin(6, 0, 1), Z0);
               SEG_W'(1): c = mk_coef(mk_lin(-6, 2, 1), ONE, Z0);
               SEG_W'(2): c = mk_coef(Z0, ONE, mk_lin(6, -2, 1));
               SEG_W'(3): c = mk_coef(Z0, mk_lin(-6, 4, 1), ONE);
               SEG_W'(4): c = mk_coef(mk_lin(6, -4, 1), Z0, ONE);
               default:   c = mk_coef(ONE, Z0, mk_lin(-6, 6, 1));
            endcase
         end
         MAP_RAINBOW3: begin
            case (seg)
               SEG_W'(0): c = mk_coef(Z0, mk_lin(4, 0, 1), mk_lin(-4, 1, 1));
               SEG_W'(1): c = mk_coef(mk_lin(4, -1, 1), mk_lin(-4, 2, 1), Z0);
               SEG_W'(2): c = mk_coef(mk_lin(-4, 3, 1), mk_lin(4, -2, 1), Z0);
               default:   c = mk_coef(Z0, mk_lin(-4, 4, 1), mk_lin(4, -3, 1));
            endcase
         end
         MAP_RAINBOW4: begin
            case (seg)
               SEG_W'(0): c = mk_coef(mk_lin(-3, 1, 1), Z0, mk_lin(3, 0, 1));
               SEG_W'(1): c = mk_coef(Z0, mk_lin(3, -1, 1), ONE);
               default:   c = mk_coef(mk_lin(3, -2, 1), mk_lin(-3, 3, 1), ONE);
            endcase
         end
         MAP_RAINBOW5: begin
            case (seg)
               SEG_W'(0): c = mk_coef(Z0, mk_lin(5, 0, 1), ONE);
               SEG_W'(1): c = mk_coef(Z0, ONE, mk_lin(-5, 2, 1));
               SEG_W'(2): c = mk_coef(mk_lin(5, -2, 1), ONE, Z0);
               SEG_W'(3): c = mk_coef(ONE, mk_lin(-5, 4, 1), Z0);
               default:   c = mk_coef(ONE, mk_lin(5, -4, 1), mk_lin(5, -4, 1));
            endcase
         end
         MAP_RAINBOW6: begin
            case (seg)
               SEG_W'(0): c = mk_coef(Z0, mk_lin(4, 0, 1), ONE);
               SEG_W'(1): c = mk_coef(Z0, ONE, mk_lin(-4, 2, 1));
               SEG_W'(2): c = mk_coef(mk_lin(4, -2, 1), ONE, Z0);
               default:   c = mk_coef(ONE, ONE, mk_lin(4, -3, 1));
            endcase
         end
         MAP_RAINBOW7: begin
            case (seg)
               SEG_W'(0): c = mk_coef(Z0, mk_lin(2, 0, 1), mk_lin(-2, 1, 1));
               default:   c = mk_coef(mk_lin(2, -1, 1), mk_lin(-2, 2, 1), Z0);
            endcase
         end
         MAP_RAINBOW8: begin
            case (seg)
               SEG_W'(0): c = mk_coef(ONE, mk_lin(-2, 1, 1), mk_lin(2, 0, 1));
               default:   c = mk_coef(mk_lin(-2, 2, 1), mk_lin(2, -1, 1), ONE);
            endcase
         end
         MAP_BLUE_RED:  c = mk_coef(TUP, Z0, TDN);
         MAP_TANGERINE: c = mk_coef(mk_lin(50, 200, 255), mk_lin(100, 60, 255),
                                    mk_lin(110, 0, 255));
         MAP_ORANGE: begin
            case (seg)
               SEG_W'(0): c = mk_coef(mk_lin(725, 110, 510), mk_lin(25, 110, 510),
                                      mk_lin(-225, 90, 510));
               default:   c = mk_coef(mk_lin(250, 500, 765), mk_lin(500, -20, 765),
                                      mk_lin(550, -220, 765));
            endcase
         end
         MAP_YELLOW_RED:   c = mk_coef(ONE, TDN, Z0);
         MAP_GRAYSCALE:    c = mk_coef(TUP, TUP, TUP);
         MAP_FLAT_GRAY:    c = mk_coef(mk_lin(0, 1, 2), mk_lin(0, 1, 2), mk_lin(0, 1, 2));
         MAP_FLAT_BLUE:    c = mk_coef(mk_lin(0, 53, 100), mk_lin(0, 95, 100),
                                       mk_lin(0, 81, 100));
         MAP_BLUES:        c = mk_coef(TUP, TUP, ONE);
         MAP_YELLOW_GREEN: c = mk_coef(TUP, ONE, Z0);
         MAP_GREEN_PINK:   c = mk_coef(TUP, TDN, TUP);
         default:          c = mk_coef(Z0, Z0, Z0);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/cmap_front.sv @@
// Front end of the colormap: configuration registers, sample intake and
// segment classification. Uses cmap_pkg; feeds cmap_queue under credit control.
`default_nettype none

module cmap_front
   import cmap_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_invalid,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [SAMPLE_BITS-1:0]        csr_wdata,
   input  logic                          q_pop_i,
   output logic                          q_push_o,
   output item_type                      q_item_o
);

   localparam int CRED_W = QCNT_W;

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [MAP_W-1:0]              map_ff, map_in;

   logic                   a_vld_ff, a_vld_in;
   logic signed [ND_W-1:0] a_n_ff, a_n_in;
   logic signed [ND_W-1:0] a_d_ff, a_d_in;
   logic                   a_bad_ff, a_bad_in;
   logic                   a_inv_ff, a_inv_in;
   logic [MAP_W-1:0]       a_map_ff, a_map_in;

   logic     b_vld_ff, b_vld_in;
   item_type b_item_ff, b_item_in;

   logic [CRED_W-1:0] cred_ff, cred_in;
   logic              accept;

   // Every transaction in the two front stages or in the queue holds one credit,
   // so the queue can never overflow.
   assign req_full = (cred_ff == CRED_W'(QDEPTH));
   assign accept   = req_push && !req_full;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      map_in = map_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RANGE_MIN:  min_in = csr_wdata;
            CSR_RANGE_MAX:  max_in = csr_wdata;
            CSR_MAP_SELECT: map_in = csr_wdata[MAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      a_vld_in = accept;
      a_n_in   = ND_W'(req_sample) - ND_W'(min_ff);
      a_d_in   = ND_W'(max_ff) - ND_W'(min_ff);
      a_bad_in = (max_ff <= min_ff);
      a_inv_in = req_sample_invalid;
      a_map_in = map_ff;
   end

   always_comb begin
      geom_type               g;
      logic [SEG_W-1:0]       seg;
      logic signed [CMP_W-1:0] lhs;
      logic signed [CMP_W-1:0] rhs;
      logic [KW-1:0]          k;
      g   = cmap_geom(a_map_ff);
      seg = '0;
      lhs = $signed({1'b0, g.m}) * a_n_ff;
      // Boundaries rise with i, so the segment is the number of boundaries passed.
      for (int i = 0; i < MAX_SEGS - 1; i++) begin
         k   = KW'(i + 1) * KW'(g.kstep);
         rhs = $signed({1'b0, k}) * a_d_ff;
         if ((SEG_W'(i + 1) < g.nseg) && (lhs >= rhs)) begin
            seg = seg + SEG_W'(1);
         end
      end
      b_vld_in             = a_vld_ff;
      b_item_in.n          = a_n_ff;
      b_item_in.d          = a_d_ff;
      b_item_in.coef       = cmap_coef(a_map_ff, seg);
      b_item_in.blank      = a_bad_ff || a_inv_ff || (a_map_ff >= MAP_W'(NUM_MAPS));
      b_item_in.force_clip = a_bad_ff;
   end

   always_comb begin
      cred_in = cred_ff;
      if (accept && !q_pop_i) begin
         cred_in = cred_ff + CRED_W'(1);
      end else if (!accept && q_pop_i) begin
         cred_in = cred_ff - CRED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= RANGE_MIN_RESET;
         max_ff   <= RANGE_MAX_RESET;
         map_ff   <= MAP_SELECT_RESET;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         cred_ff  <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         map_ff   <= map_in;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         cred_ff  <= cred_in;
      end
   end

   always_ff @(posedge clock) begin
      a_n_ff    <= a_n_in;
      a_d_ff    <= a_d_in;
      a_bad_ff  <= a_bad_in;
      a_inv_ff  <= a_inv_in;
      a_map_ff  <= a_map_in;
      b_item_ff <= b_item_in;
   end

   assign q_push_o = b_vld_ff;
   assign q_item_o = b_item_ff;

   a_cred_bound: assert property (@(posedge clock) disable iff (reset)
      cred_ff <= CRED_W'(QDEPTH))
      else $error("credit count above queue depth");

endmodule

`default_nettype wire

@@ sv/cmap_queue.sv @@
// Short queue that decouples the colormap front end from the back end.
// Uses cmap_pkg for the item type and depth.
`default_nettype none

module cmap_queue
   import cmap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_i,
   input  item_type item_i,
   input  logic     pop_i,
   output logic     valid_o,
   output item_type item_o
);

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign valid_o = (count_ff != '0);
   assign item_o  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push_i ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = pop_i ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_i && pop_i) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wptr_ff] <= item_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i && !pop_i && (count_ff == QCNT_W'(QDEPTH))))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop_i && (count_ff == '0)))
      else $error("queue read while empty");

endmodule

`default_nettype wire

@@ sv/cmap_back.sv @@
// Back end of the colormap: segment products, rounding numerator, saturation
// test, one quotient bit per stage, and a two-entry result buffer. Uses cmap_pkg.
`default_nettype none

module cmap_back
   import cmap_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid_i,
   input  item_type                q_item_i,
   output logic                    q_pop_o,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue,
   output logic                    rsp_clipped
);

   localparam int NDV = CHANNEL_BITS + 1;

   logic en;
   logic out_pop;
   logic out_push;

   // Product stage.
   logic                   p_vld_ff, p_vld_in;
   logic signed [PN_W-1:0] p_pn_ff [3], p_pn_in [3];
   logic signed [QD_W-1:0] p_qd_ff [3], p_qd_in [3];
   logic signed [RD_W-1:0] p_rd_ff [3], p_rd_in [3];
   logic                   p_blank_ff, p_blank_in;
   logic                   p_fclip_ff, p_fclip_in;

   // Numerator and divisor stage.
   logic                    s_vld_ff, s_vld_in;
   logic signed [NUM_W-1:0] s_num_ff [3], s_num_in [3];
   logic [D_W-1:0]          s_den_ff [3], s_den_in [3];
   logic                    s_blank_ff, s_blank_in;
   logic                    s_fclip_ff, s_fclip_in;

   // Division stages; stage 0 holds the saturation flags.
   logic                    dv_vld_ff   [NDV], dv_vld_in   [NDV];
   logic [NUM_W-1:0]        dv_rem_ff   [NDV][3], dv_rem_in [NDV][3];
   logic [D_W-1:0]          dv_den_ff   [NDV][3], dv_den_in [NDV][3];
   logic [CHANNEL_BITS-1:0] dv_quo_ff   [NDV][3], dv_quo_in [NDV][3];
   logic [2:0]              dv_neg_ff   [NDV], dv_neg_in   [NDV];
   logic [2:0]              dv_over_ff  [NDV], dv_over_in  [NDV];
   logic                    dv_blank_ff [NDV], dv_blank_in [NDV];
   logic                    dv_fclip_ff [NDV], dv_fclip_in [NDV];

   // Result buffer.
   rsp_type           obuf_ff [ODEPTH];
   rsp_type           res;
   logic [OPTR_W-1:0] owp_ff, owp_in;
   logic [OPTR_W-1:0] orp_ff, orp_in;
   logic [OCNT_W-1:0] ocnt_ff, ocnt_in;

   assign out_pop  = rsp_pop && (ocnt_ff != '0);
   // The whole pipeline holds only when its last stage cannot hand over.
   assign en       = !dv_vld_ff[NDV-1] || (ocnt_ff != OCNT_W'(ODEPTH)) || out_pop;
   assign q_pop_o  = q_valid_i && en;
   assign out_push = dv_vld_ff[NDV-1] && en;

   always_comb begin
      p_vld_in   = q_pop_o;
      p_blank_in = q_item_i.blank;
      p_fclip_in = q_item_i.force_clip;
      for (int c = 0; c < 3; c++) begin
         p_pn_in[c] = q_item_i.coef[c].p * q_item_i.n;
         p_qd_in[c] = q_item_i.coef[c].q * q_item_i.d;
         p_rd_in[c] = $signed({1'b0, q_item_i.coef[c].r}) * q_item_i.d;
      end
   end

   always_comb begin
      logic signed [N_W-1:0]   nsum;
      logic signed [NUM_W-1:0] nw;
      s_vld_in   = p_vld_ff;
      s_blank_in = p_blank_ff;
      s_fclip_in = p_fclip_ff;
      for (int c = 0; c < 3; c++) begin
         nsum = N_W'(p_pn_ff[c]) + N_W'(p_qd_ff[c]);
         nw   = NUM_W'(nsum);
         // 2*CMAX*N + r*d, with 2*CMAX written as a difference of shifts.
         s_num_in[c] = (nw <<< (CHANNEL_BITS + 1)) - (nw <<< 1) + NUM_W'(p_rd_ff[c]);
         s_den_in[c] = {p_rd_ff[c][RD_W-1:0], 1'b0};
      end
   end

   always_comb begin
      logic [NUM_W-1:0] lim;
      dv_vld_in[0]   = s_vld_ff;
      dv_blank_in[0] = s_blank_ff;
      dv_fclip_in[0] = s_fclip_ff;
      for (int c = 0; c < 3; c++) begin
         lim                = NUM_W'(s_den_ff[c]) << CHANNEL_BITS;
         dv_neg_in[0][c]    = s_num_ff[c] < 0;
         dv_over_in[0][c]   = (s_num_ff[c] >= 0) && ($unsigned(s_num_ff[c]) >= lim);
         dv_rem_in[0][c]    = $unsigned(s_num_ff[c]);
         dv_den_in[0][c]    = s_den_ff[c];
         dv_quo_in[0][c]    = '0;
      end
      for (int j = 0; j < CHANNEL_BITS; j++) begin
         dv_vld_in[j+1]   = dv_vld_ff[j];
         dv_blank_in[j+1] = dv_blank_ff[j];
         dv_fclip_in[j+1] = dv_fclip_ff[j];
         dv_neg_in[j+1]   = dv_neg_ff[j];
         dv_over_in[j+1]  = dv_over_ff[j];
         for (int c = 0; c < 3; c++) begin
            lim                = NUM_W'(dv_den_ff[j][c]) << (CHANNEL_BITS - 1 - j);
            dv_den_in[j+1][c]  = dv_den_ff[j][c];
            dv_rem_in[j+1][c]  = dv_rem_ff[j][c];
            dv_quo_in[j+1][c]  = dv_quo_ff[j][c];
            if (dv_rem_ff[j][c] >= lim) begin
               dv_rem_in[j+1][c] = dv_rem_ff[j][c] - lim;
               dv_quo_in[j+1][c][CHANNEL_BITS-1-j] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [CHANNEL_BITS-1:0] ch [3];
      for (int c = 0; c < 3; c++) begin
         if (dv_blank_ff[NDV-1] || dv_neg_ff[NDV-1][c]) begin
            ch[c] = '0;
         end else if (dv_over_ff[NDV-1][c]) begin
            ch[c] = CHANNEL_BITS'(CMAX);
         end else begin
            ch[c] = dv_quo_ff[NDV-1][c];
         end
      end
      res.red     = ch[0];
      res.green   = ch[1];
      res.blue    = ch[2];
      res.clipped = dv_fclip_ff[NDV-1] ||
                    (!dv_blank_ff[NDV-1] && ((dv_neg_ff[NDV-1] | dv_over_ff[NDV-1]) != '0));
   end

   always_comb begin
      owp_in  = out_push ? owp_ff + OPTR_W'(1) : owp_ff;
      orp_in  = out_pop ? orp_ff + OPTR_W'(1) : orp_ff;
      ocnt_in = ocnt_ff;
      if (out_push && !out_pop) begin
         ocnt_in = ocnt_ff + OCNT_W'(1);
      end else if (!out_push && out_pop) begin
         ocnt_in = ocnt_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         for (int j = 0; j < NDV; j++) begin
            dv_vld_ff[j] <= 1'b0;
         end
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (en) begin
            p_vld_ff <= p_vld_in;
            s_vld_ff <= s_vld_in;
            for (int j = 0; j < NDV; j++) begin
               dv_vld_ff[j] <= dv_vld_in[j];
            end
         end
         owp_ff  <= owp_in;
         orp_ff  <= orp_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_blank_ff <= p_blank_in;
         p_fclip_ff <= p_fclip_in;
         s_blank_ff <= s_blank_in;
         s_fclip_ff <= s_fclip_in;
         for (int c = 0; c < 3; c++) begin
            p_pn_ff[c]  <= p_pn_in[c];
            p_qd_ff[c]  <= p_qd_in[c];
            p_rd_ff[c]  <= p_rd_in[c];
            s_num_ff[c] <= s_num_in[c];
            s_den_ff[c] <= s_den_in[c];
         end
         for (int j = 0; j < NDV; j++) begin
            dv_neg_ff[j]   <= dv_neg_in[j];
            dv_over_ff[j]  <= dv_over_in[j];
            dv_blank_ff[j] <= dv_blank_in[j];
            dv_fclip_ff[j] <= dv_fclip_in[j];
            for (int c = 0; c < 3; c++) begin
               dv_rem_ff[j][c] <= dv_rem_in[j][c];
               dv_den_ff[j][c] <= dv_den_in[j][c];
               dv_quo_ff[j][c] <= dv_quo_in[j][c];
            end
         end
      end
      if (out_push) begin
         obuf_ff[owp_ff] <= res;
      end
   end

   assign rsp_empty   = (ocnt_ff == '0);
   assign rsp_red     = obuf_ff[orp_ff].red;
   assign rsp_green   = obuf_ff[orp_ff].green;
   assign rsp_blue    = obuf_ff[orp_ff].blue;
   assign rsp_clipped = obuf_ff[orp_ff].clipped;

   a_obuf_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCNT_W'(ODEPTH))
      else $error("result buffer count above its depth");

endmodule

`default_nettype wire

@@ sv/scalar_to_rgb_colormap.sv @@
// Scalar-to-RGB pseudocolour map, top level. An accepted request transaction passes
// the front stages, the queue and the back-end stages to the response side.
// Throughput: one transaction per cycle while the response side keeps up, set by the
// one-bit-per-stage quotient pipeline in the back end. Reset is synchronous and active
// high; it empties all stages and queues and loads range 82..486 (Q7.8) and map 0.
// Depends on cmap_pkg, cmap_front, cmap_queue and cmap_back.
`default_nettype none

module scalar_to_rgb_colormap
   import cmap_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_invalid,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [CHANNEL_BITS-1:0]       rsp_red,
   output logic [CHANNEL_BITS-1:0]       rsp_green,
   output logic [CHANNEL_BITS-1:0]       rsp_blue,
   output logic                          rsp_clipped,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [SAMPLE_BITS-1:0]        csr_wdata
);

   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type q_wr_item;
   item_type q_rd_item;

   cmap_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_sample_invalid (req_sample_invalid),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_pop_i            (q_pop),
      .q_push_o           (q_push),
      .q_item_o           (q_wr_item)
   );

   cmap_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .item_i  (q_wr_item),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .item_o  (q_rd_item)
   );

   cmap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid_i   (q_valid),
      .q_item_i    (q_rd_item),
      .q_pop_o     (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_clipped (rsp_clipped)
   );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for scalar_to_rgb_colormap: random and directed samples over several
// range and colormap settings, checked against a predictor held in a small scoreboard.
// Depends on cmap_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import cmap_pkg::*;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       clipped;
   } colour_type;

   // Holds the colours still awaited and counts mismatches.
   class colour_scoreboard;
      colour_type pending[$];
      int         errors;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic [4:0]         code;

      function new();
         errors = 0;
         lo = 16'sd82;
         hi = 16'sd486;
         code = MAP_RAINBOW1;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         if (idx == CSR_RANGE_MIN) lo = val;
         else if (idx == CSR_RANGE_MAX) hi = val;
         else if (idx == CSR_MAP_SELECT) code = val[4:0];
      endfunction

      // Rounded and saturated channel for f = (p*n + q*d) / (r*d).
      function logic [7:0] shade(int p, int q, int r, longint n, longint d,
                                 ref logic clip);
         longint num, den, v;
         num = 2 * 255 * (p * n + q * d) + r * d;
         den = 2 * r * d;
         v = num / den;
         if ((num % den) != 0 && num < 0) v = v - 1;
         if (v < 0) begin
            clip = 1'b1;
            return 8'd0;
         end
         if (v > 255) begin
            clip = 1'b1;
            return 8'd255;
         end
         return v[7:0];
      endfunction

      function void note_sample(logic signed [15:0] sample, logic invalid);
         colour_type c;
         longint n, d;
         int m, nseg, kstep, seg;
         int p[3], q[3], r[3];
         c = '{8'd0, 8'd0, 8'd0, 1'b0};
         if (hi <= lo) begin
            c.clipped = 1'b1;
         end else if (!invalid && code < NUM_MAPS) begin
            n = longint'(sample) - longint'(lo);
            d = longint'(hi) - longint'(lo);
            m = 1; nseg = 1; kstep = 1;
            case (code)
               MAP_RAINBOW1, MAP_RAINBOW3, MAP_RAINBOW6: begin m = 4; nseg = 4; end
               MAP_RAINBOW2: begin m = 6; nseg = 6; end
               MAP_RAINBOW4: begin m = 3; nseg = 3; end
               MAP_RAINBOW5: begin m = 5; nseg = 5; end
               MAP_RAINBOW7, MAP_RAINBOW8: begin m = 2; nseg = 2; end
               MAP_ORANGE: begin m = 5; nseg = 2; kstep = 2; end
               default: ;
            endcase
            seg = 0;
            for (int i = 1; i < nseg; i++)
               if (m * n >= i * kstep * d) seg = i;
            for (int i = 0; i < 3; i++) begin
               p[i] = 0; q[i] = 0; r[i] = 1;
            end
            pick(seg, p, q, r);
            c.red = shade(p[0], q[0], r[0], n, d, c.clipped);
            c.green = shade(p[1], q[1], r[1], n, d, c.clipped);
            c.blue = shade(p[2], q[2], r[2], n, d, c.clipped);
         end
         pending.push_back(c);
      endfunction

      function void set3(ref int a[3], input int x, int y, int z);
         a[0] = x; a[1] = y; a[2] = z;
      endfunction

      // Segment coefficients per channel; zero entries stay at p=0, q=0, r=1.
      function void pick(int seg, ref int p[3], ref int q[3], ref int r[3]);
         case (code)
            MAP_RAINBOW1: case (seg)
               0: begin set3(p, 0, 4, 0); set3(q, 0, 0, 1); end
               1: begin set3(p, 0, 0, -4); set3(q, 0, 1, 2); end
               2: begin set3(p, 4, 0, 0); set3(q, -2, 1, 0); end
               default: begin set3(p, 0, -4, 0); set3(q, 1, 4, 0); end
            endcase
            MAP_RAINBOW2: case (seg)
               0: begin set3(p, 0, 6, 0); set3(q, 1, 0, 0); end
               1: begin set3(p, -6, 0, 0); set3(q, 2, 1, 0); end
               2: begin set3(p, 0, 0, 6); set3(q, 0, 1, -2); end
               3: begin set3(p, 0, -6, 0); set3(q, 0, 4, 1); end
               4: begin set3(p, 6, 0, 0); set3(q, -4, 0, 1); end
               default: begin set3(p, 0, 0, -6); set3(q, 1, 0, 6); end
            endcase
            MAP_RAINBOW3: case (seg)
               0: begin set3(p, 0, 4, -4); set3(q, 0, 0, 1); end
               1: begin set3(p, 4, -4, 0); set3(q, -1, 2, 0); end
               2: begin set3(p, -4, 4, 0); set3(q, 3, -2, 0); end
               default: begin set3(p, 0, -4, 4); set3(q, 0, 4, -3); end
            endcase
            MAP_RAINBOW4: case (seg)
               0: begin set3(p, -3, 0, 3); set3(q, 1, 0, 0); end
               1: begin set3(p, 0, 3, 0); set3(q, 0, -1, 1); end
               default: begin set3(p, 3, -3, 0); set3(q, -2, 3, 1); end
            endcase
            MAP_RAINBOW5: case (seg)
               0: begin set3(p, 0, 5, 0); set3(q, 0, 0, 1); end
               1: begin set3(p, 0, 0, -5); set3(q, 0, 1, 2); end
               2: begin set3(p, 5, 0, 0); set3(q, -2, 1, 0); end
               3: begin set3(p, 0, -5, 0); set3(q, 1, 4, 0); end
               default: begin set3(p, 0, 5, 5); set3(q, 1, -4, -4); end
            endcase
            MAP_RAINBOW6: case (seg)
               0: begin set3(p, 0, 4, 0); set3(q, 0, 0, 1); end
               1: begin set3(p, 0, 0, -4); set3(q, 0, 1, 2); end
               2: begin set3(p, 4, 0, 0); set3(q, -2, 1, 0); end
               default: begin set3(p, 0, 0, 4); set3(q, 1, 1, -3); end
            endcase
            MAP_RAINBOW7: case (seg)
               0: begin set3(p, 0, 2, -2); set3(q, 0, 0, 1); end
               default: begin set3(p, 2, -2, 0); set3(q, -1, 2, 0); end
            endcase
            MAP_RAINBOW8: case (seg)
               0: begin set3(p, 0, -2, 2); set3(q, 1, 1, 0); end
               default: begin set3(p, -2, 2, 0); set3(q, 2, -1, 1); end
            endcase
            MAP_BLUE_RED: begin set3(p, 1, 0, -1); set3(q, 0, 0, 1); end
            MAP_TANGERINE: begin
               set3(p, 50, 100, 110); set3(q, 200, 60, 0); set3(r, 255, 255, 255);
            end
            MAP_ORANGE: case (seg)
               0: begin
                  set3(p, 725, 25, -225); set3(q, 110, 110, 90); set3(r, 510, 510, 510);
               end
               default: begin
                  set3(p, 250, 500, 550); set3(q, 500, -20, -220); set3(r, 765, 765, 765);
               end
            endcase
            MAP_YELLOW_RED: begin set3(p, 0, -1, 0); set3(q, 1, 1, 0); end
            MAP_GRAYSCALE: set3(p, 1, 1, 1);
            MAP_FLAT_GRAY: begin set3(q, 1, 1, 1); set3(r, 2, 2, 2); end
            MAP_FLAT_BLUE: begin set3(q, 53, 95, 81); set3(r, 100, 100, 100); end
            MAP_BLUES: begin set3(p, 1, 1, 0); set3(q, 0, 0, 1); end
            MAP_YELLOW_GREEN: begin set3(p, 1, 0, 0); set3(q, 0, 1, 0); end
            MAP_GREEN_PINK: begin set3(p, 1, -1, 1); set3(q, 0, 1, 0); end
            default: ;
         endcase
      endfunction

      function void check_colour(colour_type got);
         colour_type want;
         if (pending.size() == 0) begin
            $error("unexpected colour transaction");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
         if (got.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [15:0] req_sample = '0;
   logic req_sample_invalid = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_red, rsp_green, rsp_blue;
   logic rsp_clipped;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   colour_scoreboard board = new();
   int  quiet_cycles = 0;
   int  hold_off = 0;
   bit  drain_idle = 1'b0;
   localparam int WATCHDOG = 4000;

   always #6 clock = ~clock;

   scalar_to_rgb_colormap u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .req_sample_invalid(req_sample_invalid),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_clipped(rsp_clipped),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Input transactions are noted, and output transactions checked, at the accepting edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) board.note_sample(req_sample, req_sample_invalid);
         if (rsp_pop && !rsp_empty)
            board.check_colour('{rsp_red, rsp_green, rsp_blue, rsp_clipped});
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block fills up.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         gap = drain_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   task automatic send(logic signed [15:0] sample, logic invalid, bit gaps);
      int gap;
      gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_sample <= sample;
      req_sample_invalid <= invalid;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_reg(idx, val);
   endtask

   // Drops the request, lets the last accepted transaction be noted, then waits for the scoreboard to drain.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(logic signed [15:0] lo, logic signed [15:0] hi, logic [4:0] code);
      settle();
      write_reg(CSR_RANGE_MIN, lo);
      write_reg(CSR_RANGE_MAX, hi);
      write_reg(CSR_MAP_SELECT, code);
   endtask

   // Sample mostly inside the range, sometimes a little outside, sometimes anywhere.
   function automatic logic signed [15:0] draw_sample();
      longint lo, hi, span, v;
      lo = board.lo;
      hi = board.hi;
      span = (hi > lo) ? hi - lo : 1;
      case ($urandom_range(0, 9))
         0: return 16'($urandom());
         1, 2: v = lo + $urandom_range(0, 32'(span)) - 32'(span / 4)
                  + $urandom_range(0, 32'(span / 2));
         default: v = lo + $urandom_range(0, 32'(span));
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   initial begin
      logic signed [15:0] lo, hi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, field extremes, invalid sample.
      send(16'sh8000, 1'b0, 1'b0);
      send(16'sh7fff, 1'b0, 1'b0);
      send(16'sd82, 1'b0, 1'b0);
      send(16'sd486, 1'b0, 1'b0);
      send(16'sd183, 1'b1, 1'b0);
      send(16'sd284, 1'b0, 1'b0);
      // Extreme range, then an empty range and a reversed one.
      configure(16'sh8000, 16'sh7fff, MAP_ORANGE);
      send(16'sh8000, 1'b0, 1'b0);
      send(16'sh7fff, 1'b0, 1'b0);
      send(16'sh7fff, 1'b1, 1'b0);
      send(16'sd13106, 1'b0, 1'b0);
      configure(16'sd100, 16'sd100, MAP_GRAYSCALE);
      send(16'sd100, 1'b0, 1'b0);
      configure(16'sh7fff, 16'sh8000, MAP_GRAYSCALE);
      send(16'sd0, 1'b1, 1'b0);
      // Unknown map code, including the largest.
      configure(16'sd0, 16'sd256, 5'd31);
      send(16'sd128, 1'b0, 1'b0);
      configure(16'sd0, 16'sd256, 5'd18);
      send(16'sd128, 1'b0, 1'b0);
      // Every map with samples at the middle and a third of the range, on a segment boundary for some maps.
      for (int c = 0; c < NUM_MAPS; c++) begin
         configure(16'sd0, 16'sd60, 5'(c));
         send(16'sd30, 1'b0, 1'b0);
         send(16'sd20, 1'b0, 1'b0);
      end

      // Random phases; one phase holds the receiver off so the input stalls.
      for (int phase = 0; phase < 30; phase++) begin
         case ($urandom_range(0, 5))
            0: begin lo = 16'sh8000; hi = 16'sh7fff; end
            1: begin lo = 16'($urandom()); hi = lo + 16'sd1; end
            2: begin lo = 16'($urandom()); hi = 16'($urandom()); end
            default: begin
               lo = 16'($urandom_range(0, 8000)) - 16'sd4000;
               hi = lo + 16'($urandom_range(1, 3000));
            end
         endcase
         configure(lo, hi, (phase < 27) ? 5'($urandom_range(0, NUM_MAPS - 1))
                                        : 5'($urandom_range(0, 31)));
         if (phase == 3) hold_off = 300;
         for (int i = 0; i < 30; i++)
            send(draw_sample(), $urandom_range(0, 15) == 0, (phase % 4) != 1);
      end

      req_push <= 1'b0;
      drain_idle = 1'b1;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
